[src/fgcr_pkg.sv]
// fgcr_pkg: shared types and constants for the filter/group/compact block
// no dependencies
`timescale 1ns / 1ps

package fgcr_pkg;

  localparam int MAX_MEASURES = 4096;
  localparam int MAX_PARENTS  = 1024;
  localparam int MAX_CODES    = 4;
  localparam int MW = $clog2(MAX_MEASURES);   // measurement index width
  localparam int PW = $clog2(MAX_PARENTS);    // parent index width

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_COMPUTE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REC_NONE   = 2'd0,
    REC_MEAS   = 2'd1,
    REC_PARENT = 2'd2
  } rec_t;

  localparam logic [2:0] REG_CODE_COUNT = 3'd0;
  localparam logic [2:0] REG_CODE_A     = 3'd1;
  localparam logic [2:0] REG_CODE_B     = 3'd2;
  localparam logic [2:0] REG_CODE_C     = 3'd3;
  localparam logic [2:0] REG_CODE_D     = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  parent_ref;
    logic [15:0] meas_code;
    logic [10:0] parent_total;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_type;
    logic [11:0] source_index;
    logic [9:0]  new_parent;
    logic [12:0] kept_count;
    logic [11:0] first_offset;
    logic        is_last;
    logic        overflow;
  } out_item_t;

  // datapath operation selected by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,      // write one record
    OP_CLR,       // clear counts, address = ctr
    OP_CNT_RD,    // read record ctr
    OP_CNT_FL,    // read count of registered record's parent
    OP_CNT_WR,    // bump count of registered record
    OP_PFX_RD,    // read count of parent ctr
    OP_PFX_WR,    // write offset/fill/newindex
    OP_SRT_RD,    // read record ctr
    OP_SRT_FL,    // read fill of its parent
    OP_SRT_WR,    // write sorted slot, bump fill
    OP_RD_A,      // read step a
    OP_RD_B,      // read step b
    OP_RD_C,      // read step c
    OP_RD_D       // read step d: new parent index lands
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [MW:0] ctr;
  } dp_cmd_t;

  typedef struct packed {
    logic        kept;        // registered record is kept
    logic [MW:0] kept_meas;
    logic [PW:0] kept_par;
  } dp_stat_t;

endpackage

[src/filter_group_compact_reindex_top.sv]
// filter_group_compact_reindex_top: config registers, controller and datapath
// a read steps through RD_A, RD_B, RD_C and FIX before out_valid rises; one item in flight
// throughput: load one per cycle while idle; a new read is taken only after the previous result is accepted
// compute: clear every parent count, count each kept record, prefix-sum the parents, then sort each record
// reset: synchronous active-low rst_n; load phase, empty store, registers zero
`timescale 1ns / 1ps

module filter_group_compact_reindex_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fgcr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fgcr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import fgcr_pkg::*;

  logic [2:0]  code_count_r;
  logic [63:0] codes_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [MW:0] meas_loaded, read_ptr;
  logic [PW:0] parents;
  logic        overflow, idle_none;
  out_item_t   dp_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_count_r <= '0;
      codes_r      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CODE_COUNT: code_count_r <= cfg_data[2:0];
        REG_CODE_A:     codes_r[15:0]  <= cfg_data;
        REG_CODE_B:     codes_r[31:16] <= cfg_data;
        REG_CODE_C:     codes_r[47:32] <= cfg_data;
        REG_CODE_D:     codes_r[63:48] <= cfg_data;
        default: ;
      endcase
    end
  end

  fgcr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_item(in_data),
    .out_valid, .out_ready, .stat, .cmd, .meas_loaded, .parents,
    .read_ptr, .overflow, .idle_none
  );

  fgcr_datapath u_dp (
    .clk, .rst_n, .cmd, .in_item(in_data), .code_count(code_count_r),
    .drop_codes(codes_r), .meas_loaded, .parents, .read_ptr, .overflow,
    .stat, .result(dp_res)
  );

  always_comb begin
    out_data = dp_res;
    if (idle_none) begin
      out_data = '0;
      out_data.overflow = overflow;
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_type_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.record_type != 2'd3) else $error("bad record type");
`endif

endmodule

[src/fgcr_datapath.sv]
// fgcr_datapath: record stores, per-parent tables and result assembly
// depends on fgcr_pkg
`timescale 1ns / 1ps

module fgcr_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  fgcr_pkg::dp_cmd_t  cmd,
  input  fgcr_pkg::in_item_t in_item,
  input  logic [2:0]         code_count,
  input  logic [63:0]        drop_codes,
  input  logic [fgcr_pkg::MW:0] meas_loaded,
  input  logic [fgcr_pkg::PW:0] parents,
  input  logic [fgcr_pkg::MW:0] read_ptr,
  input  logic               overflow,
  output fgcr_pkg::dp_stat_t stat,
  output fgcr_pkg::out_item_t result
);
  import fgcr_pkg::*;

  logic [PW-1:0] mpar_mem [MAX_MEASURES];
  logic          mdrop_mem [MAX_MEASURES];
  logic [MW:0]   cnt_mem [MAX_PARENTS];
  logic [MW-1:0] off_mem [MAX_PARENTS];
  logic [MW-1:0] fill_mem [MAX_PARENTS];
  logic [PW-1:0] nidx_mem [MAX_PARENTS];
  logic [PW-1:0] klist_mem [MAX_PARENTS];
  logic [MW-1:0] sort_mem [MAX_MEASURES];

  logic [PW-1:0] rpar_r;
  logic          rdrop_r;
  logic [MW:0]   rcnt_r;
  logic [MW-1:0] rfill_r;
  logic [MW-1:0] ridx_r;
  logic [MW:0]   pos_r, pos_nxt;
  logic [PW:0]   kpar_r, kpar_nxt;
  logic [MW-1:0] rsort_r;
  logic [PW-1:0] rklist_r;
  logic [PW-1:0] rnidx_r;
  logic [MW-1:0] roff_r;
  out_item_t     res_r, res_nxt;
  logic          match;
  logic          kept_w;
  logic [MW:0]   total;
  logic [MW:0]   k;
  logic [PW-1:0] cpar;

  always_comb begin
    match = 1'b0;
    for (int j = 0; j < MAX_CODES; j++) begin
      if (32'(j) < 32'(code_count) && drop_codes[16*j +: 16] == in_item.meas_code) begin
        match = 1'b1;
      end
    end
  end

  assign kept_w = !rdrop_r && ({1'b0, rpar_r} < parents);
  assign total  = pos_r + (MW+1)'(kpar_r);
  assign cpar   = cmd.ctr[PW-1:0];
  assign k      = read_ptr - pos_r;

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mpar_mem[meas_loaded[MW-1:0]]  <= in_item.parent_ref;
        mdrop_mem[meas_loaded[MW-1:0]] <= match;
      end
      OP_CLR: cnt_mem[cpar] <= '0;
      OP_CNT_RD, OP_SRT_RD: begin
        rpar_r  <= mpar_mem[cmd.ctr[MW-1:0]];
        rdrop_r <= mdrop_mem[cmd.ctr[MW-1:0]];
        ridx_r  <= cmd.ctr[MW-1:0];
      end
      OP_CNT_FL: rcnt_r <= cnt_mem[rpar_r];
      OP_CNT_WR: if (kept_w) cnt_mem[rpar_r] <= rcnt_r + 1'b1;
      OP_PFX_RD: rcnt_r <= cnt_mem[cpar];
      OP_PFX_WR: begin
        off_mem[cpar]  <= pos_r[MW-1:0];
        fill_mem[cpar] <= pos_r[MW-1:0];
        if (rcnt_r != '0) begin
          nidx_mem[cpar]              <= kpar_r[PW-1:0];
          klist_mem[kpar_r[PW-1:0]]   <= cpar;
        end
      end
      OP_SRT_FL: rfill_r <= fill_mem[rpar_r];
      OP_SRT_WR: if (kept_w) begin
        sort_mem[rfill_r] <= ridx_r;
        fill_mem[rpar_r]  <= rfill_r + 1'b1;
      end
      OP_RD_A: begin
        rsort_r  <= sort_mem[read_ptr[MW-1:0]];
        rklist_r <= klist_mem[k[PW-1:0]];
      end
      OP_RD_B: begin
        rpar_r <= mpar_mem[rsort_r];
        rcnt_r <= cnt_mem[rklist_r];
        roff_r <= off_mem[rklist_r];
      end
      OP_RD_C: rnidx_r <= nidx_mem[rpar_r];
      default: ;
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    kpar_nxt = kpar_r;
    if (cmd.op == OP_CLR && cmd.ctr == '0) begin
      pos_nxt  = '0;
      kpar_nxt = '0;
    end else if (cmd.op == OP_PFX_WR) begin
      pos_nxt = pos_r + rcnt_r;
      if (rcnt_r != '0) kpar_nxt = kpar_r + 1'b1;
    end
  end

  // result assembly over the last two read steps
  always_comb begin
    res_nxt = res_r;
    if (cmd.op == OP_RD_C) begin
      res_nxt = '0;
      res_nxt.overflow = overflow;
      if (read_ptr < total) begin
        if (read_ptr < pos_r) begin
          res_nxt.record_type  = REC_MEAS;
          res_nxt.source_index = 12'(rsort_r);
        end else begin
          res_nxt.record_type  = REC_PARENT;
          res_nxt.source_index = 12'(rklist_r);
          res_nxt.kept_count   = 13'(rcnt_r);
          res_nxt.first_offset = 12'(roff_r);
        end
        res_nxt.is_last = (read_ptr + 1'b1) == total;
      end
    end else if (cmd.op == OP_RD_D && res_r.record_type == REC_MEAS) begin
      // new parent index arrives one step after the record's parent
      res_nxt.new_parent = 10'(rnidx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      kpar_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      kpar_r <= kpar_nxt;
    end
    res_r <= res_nxt;
  end

  assign stat.kept      = kept_w;
  assign stat.kept_meas = pos_r;
  assign stat.kept_par  = kpar_r;
  assign result         = res_r;

endmodule

[src/fgcr_ctrl.sv]
// fgcr_ctrl: sequencer for load, the compute walks and result reads
// depends on fgcr_pkg
`timescale 1ns / 1ps

module fgcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fgcr_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  input  fgcr_pkg::dp_stat_t stat,
  output fgcr_pkg::dp_cmd_t  cmd,
  output logic [fgcr_pkg::MW:0] meas_loaded,
  output logic [fgcr_pkg::PW:0] parents,
  output logic [fgcr_pkg::MW:0] read_ptr,
  output logic               overflow,
  output logic               idle_none  // read gives no record
);
  import fgcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CNT_RD, S_CNT_FL, S_CNT_WR, S_PFX_RD, S_PFX_WR,
    S_SRT_RD, S_SRT_FL, S_SRT_WR, S_RD_A, S_RD_B, S_RD_C, S_FIX, S_OUT
  } state_t;

  state_t        state_r;
  logic [MW:0]   ctr_r, loaded_r, ptr_r;
  logic [PW:0]   par_r;
  logic          ovf_r, rphase_r, outv_r;
  logic          acc;
  logic [10:0]   ptot;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign ptot     = (in_item.parent_total > 11'(MAX_PARENTS)) ? 11'(MAX_PARENTS)
                                                              : in_item.parent_total;

  always_comb begin
    cmd.ctr = ctr_r;
    unique case (state_r)
      S_IDLE:   cmd.op = (acc && kind_t'(in_item.kind) == KIND_LOAD
                          && !(rphase_r ? 1'b0 : loaded_r[MW])) ? OP_LOAD : OP_IDLE;
      S_CLR:    cmd.op = OP_CLR;
      S_CNT_RD: cmd.op = OP_CNT_RD;
      S_CNT_FL: cmd.op = OP_CNT_FL;
      S_CNT_WR: cmd.op = OP_CNT_WR;
      S_PFX_RD: cmd.op = OP_PFX_RD;
      S_PFX_WR: cmd.op = OP_PFX_WR;
      S_SRT_RD: cmd.op = OP_SRT_RD;
      S_SRT_FL: cmd.op = OP_SRT_FL;
      S_SRT_WR: cmd.op = OP_SRT_WR;
      S_RD_A:   cmd.op = OP_RD_A;
      S_RD_B:   cmd.op = OP_RD_B;
      S_RD_C:   cmd.op = OP_RD_C;
      S_FIX:    cmd.op = OP_RD_D;
      S_OUT:    cmd.op = OP_IDLE;
      default:  cmd.op = OP_IDLE;
    endcase
    if (state_r == S_IDLE && acc && kind_t'(in_item.kind) == KIND_LOAD && rphase_r) begin
      cmd.op  = OP_LOAD;
      cmd.ctr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ctr_r    <= '0;
      loaded_r <= '0;
      ptr_r    <= '0;
      par_r    <= '0;
      ovf_r    <= 1'b0;
      rphase_r <= 1'b0;
      outv_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (acc) begin
          unique case (kind_t'(in_item.kind))
            KIND_LOAD: begin
              if (rphase_r) begin
                rphase_r <= 1'b0;
                ptr_r    <= '0;
                ovf_r    <= 1'b0;
                loaded_r <= (MW+1)'(1);
              end else if (loaded_r[MW]) begin
                ovf_r <= 1'b1;
              end else begin
                loaded_r <= loaded_r + 1'b1;
              end
            end
            KIND_COMPUTE: begin
              par_r   <= ptot[PW:0];
              ctr_r   <= '0;
              state_r <= S_CLR;
            end
            KIND_READ: state_r <= S_RD_A;
            default: ;
          endcase
        end
        S_CLR: begin
          if (ctr_r == (MW+1)'(MAX_PARENTS - 1)) begin
            ctr_r   <= '0;
            state_r <= (loaded_r == '0) ? S_PFX_RD : S_CNT_RD;
          end else ctr_r <= ctr_r + 1'b1;
        end
        S_CNT_RD: state_r <= S_CNT_FL;
        S_CNT_FL: state_r <= S_CNT_WR;
        S_CNT_WR: begin
          if (ctr_r + 1'b1 == loaded_r) begin
            ctr_r   <= '0;
            state_r <= S_PFX_RD;
          end else begin
            ctr_r   <= ctr_r + 1'b1;
            state_r <= S_CNT_RD;
          end
        end
        S_PFX_RD: begin
          if ({1'b0, ctr_r[PW:0]} >= {1'b0, par_r} || ctr_r > (MW+1)'(MAX_PARENTS - 1)) begin
            ctr_r   <= '0;
            state_r <= (loaded_r == '0) ? S_IDLE : S_SRT_RD;
            if (loaded_r == '0) begin
              rphase_r <= 1'b1;
              ptr_r    <= '0;
            end
          end else state_r <= S_PFX_WR;
        end
        S_PFX_WR: begin
          ctr_r   <= ctr_r + 1'b1;
          state_r <= S_PFX_RD;
        end
        S_SRT_RD: state_r <= S_SRT_FL;
        S_SRT_FL: state_r <= S_SRT_WR;
        S_SRT_WR: begin
          if (ctr_r + 1'b1 == loaded_r) begin
            rphase_r <= 1'b1;
            ptr_r    <= '0;
            state_r  <= S_IDLE;
          end else begin
            ctr_r   <= ctr_r + 1'b1;
            state_r <= S_SRT_RD;
          end
        end
        S_RD_A: state_r <= S_RD_B;
        S_RD_B: state_r <= S_RD_C;
        S_RD_C: state_r <= S_FIX;
        S_FIX: begin
          outv_r  <= 1'b1;
          state_r <= S_OUT;
          if (rphase_r && ptr_r < stat.kept_meas + (MW+1)'(stat.kept_par)) begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        S_OUT: if (out_ready) begin
          outv_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = outv_r;
  assign meas_loaded = (state_r == S_IDLE && rphase_r) ? '0 : loaded_r;
  assign parents     = par_r;
  assign read_ptr    = ptr_r;
  assign overflow    = ovf_r;
  assign idle_none   = !rphase_r;

endmodule
